FILE: rtl/tlux_pkg.sv
// ----------------------------------------------------------------------------
// tlux_pkg
// Shared types, constants and the power table for the two-channel lux block.
// ----------------------------------------------------------------------------
package tlux_pkg;

	localparam int unsigned POWER_TABLE_ENTRIES = 64;
	localparam int unsigned IDX_W = $clog2(POWER_TABLE_ENTRIES);
	localparam int unsigned TAB_MAX = POWER_TABLE_ENTRIES - 1;

	localparam int unsigned COUNT_W = 16;
	localparam int unsigned RATIO_W = 16;
	localparam int unsigned LUX_W = 20;
	localparam int unsigned POW_W = 16;
	localparam int unsigned COEF_W = 20;
	localparam int unsigned PROD_W = COEF_W + COUNT_W;
	localparam int unsigned WIDE_W = 52;

	// divider stages in front, then region, table, two multiply stages, output
	localparam int unsigned DIV_STAGES = 4;
	localparam int unsigned LATENCY = DIV_STAGES + 5;

	// ratio thresholds, unsigned Q2.14
	localparam logic [RATIO_W-1:0] RATIO_050 = 16'd8192;
	localparam logic [RATIO_W-1:0] RATIO_061 = 16'd9994;
	localparam logic [RATIO_W-1:0] RATIO_080 = 16'd13107;
	localparam logic [RATIO_W-1:0] RATIO_130 = 16'd21299;
	localparam logic [RATIO_W-1:0] RATIO_SAT = 16'hFFFF;

	// index rounding: ratio 0.50 spans the table
	localparam int unsigned IDX_SHIFT = 13;
	localparam int unsigned IDX_HALF = 1 << (IDX_SHIFT - 1);

	// coefficients, Q0.24
	localparam logic [COEF_W-1:0] K_0304 = 20'd510027;
	localparam logic [COEF_W-1:0] K_062 = 20'd1040187;
	localparam logic [COEF_W-1:0] K_0224 = 20'd375810;
	localparam logic [COEF_W-1:0] K_031 = 20'd520094;
	localparam logic [COEF_W-1:0] K_0128 = 20'd214748;
	localparam logic [COEF_W-1:0] K_0153 = 20'd256691;
	localparam logic [COEF_W-1:0] K_00146 = 20'd24495;
	localparam logic [COEF_W-1:0] K_00112 = 20'd18790;

	// lux regions
	localparam logic [2:0] REG_POW = 3'd0;
	localparam logic [2:0] REG_LOW = 3'd1;
	localparam logic [2:0] REG_MID = 3'd2;
	localparam logic [2:0] REG_HIGH = 3'd3;
	localparam logic [2:0] REG_NONE = 3'd4;

	typedef struct packed {
		logic [COUNT_W-1:0] channel0_count;
		logic [COUNT_W-1:0] channel1_count;
	} sample_t;

	typedef struct packed {
		logic [LUX_W-1:0] lux;
		logic             divide_error;
	} result_t;

	typedef struct packed {
		logic               valid;
		sample_t            smp;
		logic [RATIO_W-1:0] ratio;
		logic               zero;
	} div_out_t;

	typedef logic [POWER_TABLE_ENTRIES-1:0][POW_W-1:0] pow_rom_t;

	// true when (p/2^16)^5 <= (k/d)^7, exact
	function automatic logic pow_fits(input logic [31:0] p, input logic [31:0] k,
			input logic [31:0] d);
		logic [191:0] lhs;
		logic [191:0] rhs;
		lhs = 192'd1;
		rhs = 192'd1;
		for (int i = 0; i < 5; i++) begin
			lhs = lhs * {160'd0, p};
			rhs = rhs << 16;
		end
		for (int i = 0; i < 7; i++) begin
			lhs = lhs * {160'd0, d};
			rhs = rhs * {160'd0, k};
		end
		return lhs <= rhs;
	endfunction

	// word k = floor(2^16 * (k/d)^1.4), d = 2*(entries-1), by bitwise search
	function automatic pow_rom_t build_pow_rom();
		pow_rom_t rom;
		logic [31:0] d;
		logic [31:0] p;
		rom = '0;
		d = 32'(2 * TAB_MAX);
		for (int k = 0; k < POWER_TABLE_ENTRIES; k++) begin
			p = 32'd0;
			for (int b = POW_W - 1; b >= 0; b--) begin
				if (pow_fits(p | (32'd1 << b), 32'(k), d)) begin
					p = p | (32'd1 << b);
				end
			end
			rom[k] = p[POW_W-1:0];
		end
		return rom;
	endfunction

	localparam pow_rom_t POW_ROM = build_pow_rom();

endpackage

FILE: rtl/tlux_div.sv
// ----------------------------------------------------------------------------
// tlux_div
// Pipelined restoring divider forming ratio = (ch1 << 14) / ch0, saturated.
// ----------------------------------------------------------------------------
module tlux_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  tlux_pkg::sample_t   in_smp,
	output tlux_pkg::div_out_t  out
);

	typedef struct packed {
		logic [15:0] rem;
		logic [15:0] quo;
	} div_state_t;

	// four quotient bits per call, dbits brought in msb first
	function automatic div_state_t div_steps(input div_state_t st, input logic [3:0] dbits,
			input logic [15:0] d);
		div_state_t r;
		logic [16:0] trial;
		r = st;
		for (int i = 3; i >= 0; i--) begin
			trial = {r.rem, dbits[i]};
			if (trial >= {1'b0, d}) begin
				r.rem = 16'(trial - {1'b0, d});
				r.quo = {r.quo[14:0], 1'b1};
			end else begin
				r.rem = trial[15:0];
				r.quo = {r.quo[14:0], 1'b0};
			end
		end
		return r;
	endfunction

	div_state_t        init_st;
	div_state_t        st_s1, st_s2, st_s3, st_s4;
	tlux_pkg::sample_t smp_s1, smp_s2, smp_s3, smp_s4;
	logic              vld_s1, vld_s2, vld_s3, vld_s4;
	logic              sat_s1, sat_s2, sat_s3, sat_s4;
	logic              zero_s1, zero_s2, zero_s3, zero_s4;

	// quotient fits 16 bits unless ch1 >= 4*ch0, so the top dividend bits start the remainder
	assign init_st.rem = {2'b00, in_smp.channel1_count[15:2]};
	assign init_st.quo = 16'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		smp_s1 <= in_smp;
		zero_s1 <= (in_smp.channel0_count == 16'd0);
		sat_s1 <= ({2'b00, in_smp.channel1_count} >= {in_smp.channel0_count, 2'b00});
		st_s1 <= div_steps(init_st, {in_smp.channel1_count[1:0], 2'b00},
			in_smp.channel0_count);

		smp_s2 <= smp_s1;
		zero_s2 <= zero_s1;
		sat_s2 <= sat_s1;
		st_s2 <= div_steps(st_s1, 4'd0, smp_s1.channel0_count);

		smp_s3 <= smp_s2;
		zero_s3 <= zero_s2;
		sat_s3 <= sat_s2;
		st_s3 <= div_steps(st_s2, 4'd0, smp_s2.channel0_count);

		smp_s4 <= smp_s3;
		zero_s4 <= zero_s3;
		sat_s4 <= sat_s3;
		st_s4 <= div_steps(st_s3, 4'd0, smp_s3.channel0_count);
	end

	assign out.valid = vld_s4;
	assign out.smp = smp_s4;
	assign out.zero = zero_s4;
	assign out.ratio = sat_s4 ? tlux_pkg::RATIO_SAT : st_s4.quo;

endmodule

FILE: rtl/two_channel_lux_calculation.sv
// ----------------------------------------------------------------------------
// two_channel_lux_calculation
// Lux from a broadband / infrared count pair by the piecewise ratio formula.
// ----------------------------------------------------------------------------
// channel | signals                 | handshake
// sample  | start, busy, sample     | taken when start high and busy low
// result  | done, result            | one-cycle strobe, cannot be held off
//
// one item enters every cycle; busy is always low
// each item passes through four divider stages, then region/index,
// table read, two multiply stages and the output stage
// reset clears the valid bits only; items in flight are dropped
// there is no stall anywhere in the pipeline
// ----------------------------------------------------------------------------
module two_channel_lux_calculation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  tlux_pkg::sample_t  sample,
	output logic               done,
	output tlux_pkg::result_t  result
);

	localparam int unsigned IDX_PROD_W = tlux_pkg::RATIO_W + tlux_pkg::IDX_W + 1;
	localparam int unsigned IDX_FULL_W = IDX_PROD_W - tlux_pkg::IDX_SHIFT;

	tlux_pkg::div_out_t div_out;

	tlux_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.in_smp   (sample),
		.out      (div_out)
	);

	assign busy = 1'b0;

	// stage 5: region and table index
	logic [IDX_PROD_W-1:0]     idx_prod;
	logic [IDX_FULL_W-1:0]     idx_full;
	logic [tlux_pkg::IDX_W-1:0] idx_c;
	logic [2:0]                region_c;

	always_comb begin
		idx_prod = IDX_PROD_W'(div_out.ratio) * IDX_PROD_W'(tlux_pkg::TAB_MAX)
			+ IDX_PROD_W'(tlux_pkg::IDX_HALF);
		idx_full = idx_prod[IDX_PROD_W-1:tlux_pkg::IDX_SHIFT];
		if (idx_full > IDX_FULL_W'(tlux_pkg::TAB_MAX)) begin
			idx_c = tlux_pkg::IDX_W'(tlux_pkg::TAB_MAX);
		end else begin
			idx_c = idx_full[tlux_pkg::IDX_W-1:0];
		end
		priority if (div_out.ratio <= tlux_pkg::RATIO_050) begin
			region_c = tlux_pkg::REG_POW;
		end else if (div_out.ratio <= tlux_pkg::RATIO_061) begin
			region_c = tlux_pkg::REG_LOW;
		end else if (div_out.ratio <= tlux_pkg::RATIO_080) begin
			region_c = tlux_pkg::REG_MID;
		end else if (div_out.ratio <= tlux_pkg::RATIO_130) begin
			region_c = tlux_pkg::REG_HIGH;
		end else begin
			region_c = tlux_pkg::REG_NONE;
		end
	end

	logic                       vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	tlux_pkg::sample_t          smp_s5;
	logic                       zero_s5, zero_s6, zero_s7, zero_s8;
	logic [2:0]                 region_s5, region_s6, region_s7, region_s8;
	logic [tlux_pkg::IDX_W-1:0] idx_s5;

	// stage 6: table read and the two linear products
	logic [tlux_pkg::COEF_W-1:0] ka_c, kb_c;
	logic [tlux_pkg::POW_W-1:0]  pow_s6;
	logic [tlux_pkg::COUNT_W-1:0] ch0_s6;
	logic [tlux_pkg::PROD_W-1:0] a_prod_s6, a_prod_s7;
	logic [tlux_pkg::PROD_W-1:0] b_prod_s6, b_prod_s7;

	always_comb begin
		unique case (region_s5)
			tlux_pkg::REG_POW: begin
				ka_c = tlux_pkg::K_0304;
				kb_c = '0;
			end
			tlux_pkg::REG_LOW: begin
				ka_c = tlux_pkg::K_0224;
				kb_c = tlux_pkg::K_031;
			end
			tlux_pkg::REG_MID: begin
				ka_c = tlux_pkg::K_0128;
				kb_c = tlux_pkg::K_0153;
			end
			tlux_pkg::REG_HIGH: begin
				ka_c = tlux_pkg::K_00146;
				kb_c = tlux_pkg::K_00112;
			end
			default: begin
				ka_c = '0;
				kb_c = '0;
			end
		endcase
	end

	// stage 7: ch0 * ratio^1.4
	logic [31:0] p_s7;

	// stage 8: both terms aligned to 2^-40 lux
	logic [tlux_pkg::WIDE_W-1:0] a_s8, b_s8;

	// stage 9: difference, round half up, clamp at zero; zero also for ch0 = 0 or no region
	logic [tlux_pkg::WIDE_W-1:0] diff_c, round_c;
	logic [tlux_pkg::LUX_W-1:0]  lux_c;
	tlux_pkg::result_t           result_s9;

	always_comb begin
		diff_c = a_s8 - b_s8;
		round_c = diff_c + tlux_pkg::WIDE_W'(32'h8000_0000);
		// the top 20 bits cannot exceed the lux ceiling
		if (zero_s8 || region_s8 == tlux_pkg::REG_NONE || b_s8 >= a_s8) begin
			lux_c = '0;
		end else begin
			lux_c = round_c[tlux_pkg::WIDE_W-1:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s5 <= div_out.valid;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		smp_s5 <= div_out.smp;
		zero_s5 <= div_out.zero;
		region_s5 <= region_c;
		idx_s5 <= idx_c;

		pow_s6 <= tlux_pkg::POW_ROM[idx_s5];
		ch0_s6 <= smp_s5.channel0_count;
		a_prod_s6 <= tlux_pkg::PROD_W'(ka_c) * tlux_pkg::PROD_W'(smp_s5.channel0_count);
		b_prod_s6 <= tlux_pkg::PROD_W'(kb_c) * tlux_pkg::PROD_W'(smp_s5.channel1_count);
		zero_s6 <= zero_s5;
		region_s6 <= region_s5;

		p_s7 <= 32'(ch0_s6) * 32'(pow_s6);
		a_prod_s7 <= a_prod_s6;
		b_prod_s7 <= b_prod_s6;
		zero_s7 <= zero_s6;
		region_s7 <= region_s6;

		a_s8 <= {a_prod_s7, 16'd0};
		if (region_s7 == tlux_pkg::REG_POW) begin
			b_s8 <= tlux_pkg::WIDE_W'(tlux_pkg::K_062) * tlux_pkg::WIDE_W'(p_s7);
		end else begin
			b_s8 <= {b_prod_s7, 16'd0};
		end
		zero_s8 <= zero_s7;
		region_s8 <= region_s7;

		result_s9.lux <= lux_c;
		result_s9.divide_error <= zero_s8;
	end

	assign done = vld_s9;
	assign result = result_s9;

endmodule

FILE: rtl/tlux_checker.sv
// ----------------------------------------------------------------------------
// tlux_checker
// Port-level checks on latency and the special cases of the lux block.
// ----------------------------------------------------------------------------
module tlux_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input tlux_pkg::sample_t  sample,
	input logic               done,
	input tlux_pkg::result_t  result
);

	// every accepted item gives its result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(tlux_pkg::LATENCY) done)
		else $error("accepted item gave no result at the expected cycle");

	// no result without an item that fed it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, tlux_pkg::LATENCY))
		else $error("result strobe without a matching item");

	// zero broadband count flags the error and forces zero lux
	a_zero_ch0: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && sample.channel0_count == 16'd0) |-> ##(tlux_pkg::LATENCY)
		(done && result.divide_error && result.lux == '0))
		else $error("zero channel 0 not flagged");

	// large infrared share lies above every region
	a_high_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && sample.channel0_count != 16'd0
		&& {2'b00, sample.channel1_count} >= {sample.channel0_count, 2'b00})
		|-> ##(tlux_pkg::LATENCY) (done && !result.divide_error && result.lux == '0))
		else $error("saturated ratio gave non-zero lux");

endmodule

bind two_channel_lux_calculation tlux_checker u_tlux_checker (.*);
